### rtl/lzfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzfb_pkg
// Shared types and constants of the flag-byte LZSS decoder: item structs,
// command format between front and back, history and lane sizing.
// ----------------------------------------------------------------------------
package lzfb_pkg;

  // History ring; the depth must be a power of two so that pointers wrap
  localparam int HISTORY_BYTES = 65536;
  localparam int HIST_AW       = $clog2(HISTORY_BYTES);

  // Output lanes per result, clamped to the eight lane fields
  localparam int LANES       = 8;
  localparam int LANE_FIELDS = 8;
  localparam int LANES_USED  = (LANES < 1) ? 1 : ((LANES > LANE_FIELDS) ? LANE_FIELDS : LANES);
  localparam int CNT_W       = 4;

  // Match format
  localparam int MIN_LEN = 3;
  localparam int LEN_W   = 9;
  localparam int DIST_W  = 16;

  // Produced-byte count saturates at 64 KiB
  localparam int PROD_W               = 17;
  localparam logic [PROD_W-1:0] PRODUCED_MAX = 17'd65536;

  // Flag byte slots
  localparam logic [3:0] SLOT_FLAG = 4'd8;

  // Command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIST  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_STAT
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       lane0;
    logic [7:0]       lane1;
    logic [7:0]       lane2;
    logic [7:0]       lane3;
    logic [7:0]       lane4;
    logic [7:0]       lane5;
    logic [7:0]       lane6;
    logic [7:0]       lane7;
    logic [CNT_W-1:0] byte_count;
    status_e          status;
    logic             run_end;
    logic             stream_end;
  } out_item_t;

  // One classified command: literal byte, match, or status-only result
  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        data;    // literal byte or length code
    logic [DIST_W-1:0] distance;
    status_e           status;
    logic              last;
  } cmd_t;

endpackage

### rtl/lzfb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzfb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module lzfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lzfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzfb_front
// Stream parser: tracks flag bits, match token bytes and the produced count,
// checks distances and turns each input item into at most one command.
// ----------------------------------------------------------------------------
module lzfb_front import lzfb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_stall_o,
  input  logic     cmd_full_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic [PROD_W-1:0] produced_q, produced_d;
  logic [7:0]        flag_q, flag_d;
  logic [3:0]        slot_q, slot_d;
  logic [1:0]        phase_q, phase_d;
  logic [7:0]        dist_lo_q, dist_lo_d;
  logic [7:0]        dist_hi_q, dist_hi_d;
  logic              failed_q, failed_d;
  status_e           fail_code_q, fail_code_d;

  logic              accept;
  logic [DIST_W-1:0] match_dist;
  logic [PROD_W-1:0] len_ext;
  logic [PROD_W-1:0] prod_sum;
  logic              bad_dist;
  logic              restart;

  assign in_stall_o = cmd_full_i;
  assign accept     = in_valid_i && !cmd_full_i;

  // Match operands for the length byte
  assign match_dist = {dist_hi_q, dist_lo_q};
  assign len_ext    = PROD_W'(in_data_i.in_byte) + PROD_W'(MIN_LEN);
  assign prod_sum   = produced_q + len_ext;
  assign bad_dist   = (match_dist == '0) || ({1'b0, match_dist} > produced_q)
                   || ({1'b0, match_dist} > PROD_W'(HISTORY_BYTES));

  // Classify the accepted item
  always_comb begin
    produced_d  = produced_q;
    flag_d      = flag_q;
    slot_d      = slot_q;
    phase_d     = phase_q;
    dist_lo_d   = dist_lo_q;
    dist_hi_d   = dist_hi_q;
    failed_d    = failed_q;
    fail_code_d = fail_code_q;
    restart     = 1'b0;
    cmd_push_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.last  = in_data_i.in_last;
    cmd_o.data  = in_data_i.in_byte;
    cmd_o.distance = match_dist;
    cmd_o.kind  = CMD_STAT;
    cmd_o.status = ST_OK;

    if (accept) begin
      if (failed_q) begin
        // drop input until the stream ends, then report the stored error
        if (in_data_i.in_last) begin
          cmd_push_o   = 1'b1;
          cmd_o.status = fail_code_q;
          restart      = 1'b1;
        end
      end else if (slot_q >= SLOT_FLAG) begin
        flag_d  = in_data_i.in_byte;
        slot_d  = '0;
        phase_d = '0;
        if (in_data_i.in_last) begin
          cmd_push_o = 1'b1;
          restart    = 1'b1;
        end
      end else if (flag_q[slot_q[2:0]]) begin
        case (phase_q)
          2'd0: begin
            dist_lo_d = in_data_i.in_byte;
            phase_d   = 2'd1;
          end
          2'd1: begin
            dist_hi_d = in_data_i.in_byte;
            phase_d   = 2'd2;
          end
          default: begin
            phase_d = '0;
            slot_d  = slot_q + 4'd1;
          end
        endcase
        if (phase_q != 2'd2) begin
          // token cut off by the end of the stream
          if (in_data_i.in_last) begin
            cmd_push_o   = 1'b1;
            cmd_o.status = ST_TRUNCATED;
            restart      = 1'b1;
          end
        end else if (bad_dist) begin
          cmd_push_o   = 1'b1;
          cmd_o.status = ST_BAD_DIST;
          if (in_data_i.in_last) begin
            restart = 1'b1;
          end else begin
            failed_d    = 1'b1;
            fail_code_d = ST_BAD_DIST;
          end
        end else begin
          cmd_push_o = 1'b1;
          cmd_o.kind = CMD_COPY;
          produced_d = (prod_sum > PRODUCED_MAX) ? PRODUCED_MAX : prod_sum;
          restart    = in_data_i.in_last;
        end
      end else begin
        cmd_push_o = 1'b1;
        cmd_o.kind = CMD_LIT;
        slot_d     = slot_q + 4'd1;
        produced_d = (produced_q == PRODUCED_MAX) ? PRODUCED_MAX
                                                  : produced_q + PROD_W'(1);
        restart    = in_data_i.in_last;
      end

      // return to the start-of-stream state
      if (restart) begin
        produced_d  = '0;
        flag_d      = '0;
        slot_d      = SLOT_FLAG;
        phase_d     = '0;
        dist_lo_d   = '0;
        dist_hi_d   = '0;
        failed_d    = 1'b0;
        fail_code_d = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      produced_q  <= '0;
      flag_q      <= '0;
      slot_q      <= SLOT_FLAG;
      phase_q     <= '0;
      dist_lo_q   <= '0;
      dist_hi_q   <= '0;
      failed_q    <= 1'b0;
      fail_code_q <= ST_OK;
    end else begin
      produced_q  <= produced_d;
      flag_q      <= flag_d;
      slot_q      <= slot_d;
      phase_q     <= phase_d;
      dist_lo_q   <= dist_lo_d;
      dist_hi_q   <= dist_hi_d;
      failed_q    <= failed_d;
      fail_code_q <= fail_code_d;
    end
  end

endmodule

### rtl/lzfb_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzfb_cmd_fifo
// Short command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzfb_cmd_fifo import lzfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t data_o,
  input  logic pop_i
);

  cmd_t            entry_q [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_AW:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (CMD_AW + 1)'(CMD_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CMD_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CMD_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (CMD_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (CMD_AW + 1)'(1);
      end
    end
  end

endmodule

### rtl/lzfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzfb_back
// Copy engine: writes decoded bytes into the history ring, expands matches
// one byte per cycle unless output stalls and packs them into lane results.
// ----------------------------------------------------------------------------
module lzfb_back import lzfb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // History write side
  logic [HIST_AW-1:0] wp_q, wp_d;
  logic [7:0]         last_q, last_d;

  // Lane accumulator
  logic [7:0]       lane_q [LANE_FIELDS];
  logic [7:0]       lane_d [LANE_FIELDS];
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Match in progress
  logic               cp_q, cp_d;
  logic               d1_q, d1_d;
  logic               pend_q, pend_d;
  logic               fin_q, fin_d;
  logic               end_q, end_d;
  logic [HIST_AW-1:0] rp_q, rp_d;
  logic [LEN_W-1:0]   remain_q, remain_d;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic       out_free, full;
  logic       src_valid, consume, last_byte, issue, take, flush, push;
  logic       ram_we;
  logic [7:0] ram_wdata, ram_rdata, src_byte;
  logic [7:0] lane_out [LANE_FIELDS];

  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (cnt_q == CNT_W'(LANES_USED));

  // Byte source: last byte for distance one, else the history read
  assign src_valid = cp_q && !fin_q && (d1_q ? (remain_q != '0) : pend_q);
  assign src_byte  = d1_q ? last_q : ram_rdata;
  assign consume   = src_valid && (!full || out_free);
  assign last_byte = consume && (d1_q ? (remain_q == LEN_W'(1)) : (remain_q == '0));
  assign issue     = cp_q && !d1_q && (remain_q != '0) && (!pend_q || consume);
  assign flush     = cp_q && (fin_q || full) && out_free;
  assign take      = !cp_q && cmd_valid_i && ((cmd_i.kind == CMD_COPY) || out_free);
  assign push      = flush || (take && (cmd_i.kind != CMD_COPY));
  assign cmd_pop_o = take;

  assign ram_we    = consume || (take && (cmd_i.kind == CMD_LIT));
  assign ram_wdata = take ? cmd_i.data : src_byte;

  lzfb_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_BYTES)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  // Mask lanes at or above the count
  always_comb begin
    for (int j = 0; j < LANE_FIELDS; j++) begin
      lane_out[j] = (CNT_W'(j) < cnt_q) ? lane_q[j] : 8'h00;
    end
  end

  // Next state of the engine
  always_comb begin
    wp_d        = wp_q;
    last_d      = last_q;
    lane_d      = lane_q;
    cnt_d       = cnt_q;
    cp_d        = cp_q;
    d1_d        = d1_q;
    pend_d      = issue || (pend_q && !consume);
    fin_d       = fin_q;
    end_d       = end_q;
    rp_d        = rp_q;
    remain_d    = remain_q;
    out_valid_d = push || (out_valid_q && out_stall_i);
    out_d       = out_q;

    // history write pointer follows every decoded byte
    if (ram_we) begin
      wp_d   = wp_q + HIST_AW'(1);
      last_d = ram_wdata;
    end

    // start a command; a match leaves the output register alone
    if (take) begin
      case (cmd_i.kind)
        CMD_LIT: begin
          out_d            = '0;
          out_d.lane0      = cmd_i.data;
          out_d.byte_count = CNT_W'(1);
          out_d.run_end    = 1'b1;
          out_d.stream_end = cmd_i.last;
        end
        CMD_COPY: begin
          cp_d     = 1'b1;
          d1_d     = (cmd_i.distance == DIST_W'(1));
          rp_d     = wp_q - HIST_AW'(cmd_i.distance);
          remain_d = LEN_W'(cmd_i.data) + LEN_W'(MIN_LEN);
          end_d    = cmd_i.last;
          fin_d    = 1'b0;
          pend_d   = 1'b0;
        end
        default: begin
          out_d            = '0;
          out_d.status     = cmd_i.status;
          out_d.run_end    = 1'b1;
          out_d.stream_end = cmd_i.last;
        end
      endcase
    end

    // advance the match
    if (issue) begin
      rp_d     = rp_q + HIST_AW'(1);
      remain_d = remain_q - LEN_W'(1);
    end else if (consume && d1_q) begin
      remain_d = remain_q - LEN_W'(1);
    end
    if (last_byte) begin
      fin_d = 1'b1;
    end

    // hand a full or final lane group to the output register
    if (flush) begin
      out_d.lane0      = lane_out[0];
      out_d.lane1      = lane_out[1];
      out_d.lane2      = lane_out[2];
      out_d.lane3      = lane_out[3];
      out_d.lane4      = lane_out[4];
      out_d.lane5      = lane_out[5];
      out_d.lane6      = lane_out[6];
      out_d.lane7      = lane_out[7];
      out_d.byte_count = cnt_q;
      out_d.status     = ST_OK;
      out_d.run_end    = fin_q;
      out_d.stream_end = fin_q && end_q;
      if (fin_q) begin
        cp_d  = 1'b0;
        fin_d = 1'b0;
      end
      cnt_d = consume ? CNT_W'(1) : '0;
      if (consume) begin
        lane_d[0] = src_byte;
      end
    end else if (consume) begin
      for (int j = 0; j < LANE_FIELDS; j++) begin
        if (cnt_q == CNT_W'(j)) begin
          lane_d[j] = src_byte;
        end
      end
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    lane_q   <= lane_d;
    rp_q     <= rp_d;
    remain_q <= remain_d;
    d1_q     <= d1_d;
    end_q    <= end_d;
    out_q    <= out_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      cnt_q       <= '0;
      cp_q        <= 1'b0;
      pend_q      <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      cp_q        <= cp_d;
      pend_q      <= pend_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Accumulator never overfills
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LANES_USED))
    else $error("lane accumulator over its lane count");

  // Accumulator is empty between commands
  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cp_q |-> (cnt_q == '0) && !pend_q && !fin_q)
    else $error("engine idle with bytes still held");

  // A history read is only in flight for a long-distance match
  a_pend_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> cp_q && !d1_q)
    else $error("history read pending outside a long-distance match");

  // A finished match holds at least one byte and no reads left
  a_fin_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (remain_q == '0) && !pend_q && (cnt_q != '0))
    else $error("match finished in an inconsistent state");

endmodule

### rtl/lz77_flag_byte_decompressor_top.sv
`timescale 1ns / 1ps
// A literal's result passes through the command queue and the output register
//   before it is offered; a match's bytes also pass the history read, except at
//   distance one, where they come from the last-byte register.
// Throughput: one compressed byte per cycle for flag, literal and distance
//   bytes unless the command queue is full; no command starts during a match.
// Reset: clears all control state; history contents are not cleared.
// ----------------------------------------------------------------------------
// lz77_flag_byte_decompressor_top
// Flag-byte LZSS decoder: parser front, command queue and copy engine with
// a 64 KiB history ring, results of up to eight bytes.
// ----------------------------------------------------------------------------
module lz77_flag_byte_decompressor_top import lzfb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic cmd_push, cmd_full, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_out;

  // Parse the stream into commands
  lzfb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // Decouple parser and copy engine
  lzfb_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .valid_o (cmd_valid),
    .data_o  (cmd_out),
    .pop_i   (cmd_pop)
  );

  // Carry out commands and pack results
  lzfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
